// File: rtl/core/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Types and constants shared by the stripe request splitter.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int ADDR_W = 48;
  localparam int LEN_W  = 25;
  localparam int BS_W   = 21;
  localparam int NV_W   = 4;

  localparam logic [1:0] KIND_SEEK  = 2'd0;
  localparam logic [1:0] KIND_CHUNK = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  localparam logic [1:0] OP_NONE = 2'd2;

  localparam logic [BS_W-1:0] DEF_BLOCK = 21'd8192;
  localparam logic [BS_W-1:0] MAX_BLOCK = 21'd1048576;

  localparam logic CFG_NUM_VOLUMES = 1'b0;
  localparam logic CFG_BLOCK_SIZE  = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] start_byte;
    logic [LEN_W-1:0]  req_length;
  } req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        volume;
    logic [ADDR_W-1:0] vol_offset;
    logic [BS_W-1:0]   chunk_length;
    logic [LEN_W-1:0]  buf_offset;
    logic              op_echo;
    logic              is_last;
  } res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic              sub;
  } alu_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] sum;
    logic              carry;
  } alu_res_t;

endpackage

// File: rtl/core/srs_stream_if.sv
// ----------------------------------------------------------------------------
// srs_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface srs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/srs_alu.sv
// ----------------------------------------------------------------------------
// srs_alu
// Shared 48-bit adder/subtractor with carry out (when subtracting, carry set means a >= b).
// ----------------------------------------------------------------------------
module srs_alu (
  input  srs_pkg::alu_req_t req_i,
  output srs_pkg::alu_res_t res_o
);
  logic [srs_pkg::ADDR_W-1:0] b_op;
  logic [srs_pkg::ADDR_W:0]   total;

  assign b_op  = req_i.sub ? ~req_i.b : req_i.b;
  assign total = {1'b0, req_i.a} + {1'b0, b_op} + {{srs_pkg::ADDR_W{1'b0}}, req_i.sub};

  assign res_o.sum   = total[srs_pkg::ADDR_W-1:0];
  assign res_o.carry = total[srs_pkg::ADDR_W];
endmodule

// File: rtl/core/srs_core.sv
// ----------------------------------------------------------------------------
// srs_core
// Sequencer around the shared adder: divide, search volume, multiply, add, count, then emit.
// ----------------------------------------------------------------------------
module srs_core #(
  parameter int MAX_VOLUMES = 8,
  parameter int MAX_CHUNKS  = 56,
  parameter int ADDR_BITS   = 48,
  localparam int NVW = $clog2(MAX_VOLUMES + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [NVW-1:0]           n_i,
  input  logic [srs_pkg::BS_W-1:0] bs_i,
  srs_stream_if.sink               req_i,
  srs_stream_if.source             res_o
);
  localparam int AW  = (ADDR_BITS < srs_pkg::ADDR_W) ? ADDR_BITS : srs_pkg::ADDR_W;
  localparam int SW  = 20 + NVW;
  localparam int CW  = $clog2(MAX_CHUNKS + 2);
  localparam int STW = $clog2(srs_pkg::ADDR_W);
  localparam int DW  = srs_pkg::ADDR_W;
  localparam int LW  = srs_pkg::LEN_W;
  localparam int BW  = srs_pkg::BS_W;
  localparam logic [DW-1:0] AMASK = {{(DW-AW){1'b0}}, {AW{1'b1}}};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_FVOL  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_RBW   = 4'd4;
  localparam logic [3:0] S_RBB   = 4'd5;
  localparam logic [3:0] S_NXT   = 4'd6;
  localparam logic [3:0] S_CNT   = 4'd7;
  localparam logic [3:0] S_SEEK  = 4'd8;
  localparam logic [3:0] S_CHUNK = 4'd9;
  localparam logic [3:0] S_ERR   = 4'd10;

  logic [3:0]     state_q, state_d;
  logic           out_v_q;
  logic [AW-1:0]  expn_q;
  logic [1:0]     last_op_q;
  srs_pkg::res_t  res_q, res_n;

  logic [DW-1:0]  first_q, quo_q, acc_q, rbw_q, rnext_q;
  logic [AW-1:0]  nexp_q;
  logic [LW-1:0]  len_q, r_q, left_q, done_q;
  logic           op_q, first_chunk_q;
  logic [NVW-1:0] n_q, fvol_q, sidx_q, vol_q;
  logic [BW-1:0]  bs_q, mplr_q;
  logic [SW-1:0]  span_q, rem_q;
  logic [CW-1:0]  cnt_q, cnt_inc;
  logic [STW-1:0] step_q;

  srs_pkg::alu_req_t alu_req;
  srs_pkg::alu_res_t alu_res;

  logic           accept, load_en, ge, seek_need, last_seek, vol_wrap;
  logic [SW:0]    div_t;
  logic [BW-1:0]  firstlen, cap, clen;
  logic [LW-1:0]  left_n;
  logic [NVW+2:0] sidx_x, vol_x;

  srs_alu u_alu (.req_i(alu_req), .res_o(alu_res));

  assign accept    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign res_o.valid = out_v_q;
  assign res_o.data  = res_q;
  assign load_en   = ((state_q == S_SEEK) || (state_q == S_CHUNK) || (state_q == S_ERR))
                     && (!out_v_q || res_o.ready);

  assign ge        = alu_res.carry;
  assign div_t     = {rem_q, quo_q[DW-1]};
  assign firstlen  = bs_q - rem_q[BW-1:0];
  assign cnt_inc   = cnt_q + 1'b1;
  assign seek_need = (expn_q != first_q[AW-1:0]) || (last_op_q != {1'b0, op_q});
  assign last_seek = (sidx_q == n_q - 1'b1);
  assign vol_wrap  = (vol_q == n_q - 1'b1);
  assign cap       = first_chunk_q ? firstlen : bs_q;
  assign clen      = ({{(LW-BW){1'b0}}, cap} < left_q) ? cap : left_q[BW-1:0];
  assign left_n    = left_q - {{(LW-BW){1'b0}}, clen};
  assign sidx_x    = {3'b000, sidx_q};
  assign vol_x     = {3'b000, vol_q};

  always_comb begin
    alu_req = '0;
    case (state_q)
      S_DIV: begin
        alu_req.a   = DW'(div_t);
        alu_req.b   = DW'(span_q);
        alu_req.sub = 1'b1;
      end
      S_FVOL: begin
        alu_req.a   = DW'(rem_q);
        alu_req.b   = DW'(bs_q);
        alu_req.sub = 1'b1;
      end
      S_MUL: begin
        alu_req.a = acc_q;
        alu_req.b = quo_q;
      end
      S_RBW: begin
        alu_req.a = acc_q;
        alu_req.b = DW'(rem_q);
      end
      S_RBB: begin
        alu_req.a = acc_q;
        alu_req.b = DW'(bs_q);
      end
      S_NXT: begin
        alu_req.a = first_q;
        alu_req.b = DW'(len_q);
      end
      S_CNT: begin
        alu_req.a   = DW'(r_q);
        alu_req.b   = DW'(bs_q);
        alu_req.sub = 1'b1;
      end
      S_CHUNK: begin
        alu_req.a = rnext_q;
        alu_req.b = DW'(bs_q);
      end
      default: alu_req = '0;
    endcase
  end

  always_comb begin
    res_n         = '0;
    res_n.op_echo = op_q;
    case (state_q)
      S_SEEK: begin
        res_n.kind   = srs_pkg::KIND_SEEK;
        res_n.volume = sidx_x[2:0];
        if (sidx_q < fvol_q) begin
          res_n.vol_offset = rnext_q;
        end else if (sidx_q == fvol_q) begin
          res_n.vol_offset = rbw_q;
        end else begin
          res_n.vol_offset = acc_q;
        end
        res_n.is_last = last_seek && (len_q == '0);
      end
      S_CHUNK: begin
        res_n.kind         = srs_pkg::KIND_CHUNK;
        res_n.volume       = vol_x[2:0];
        res_n.vol_offset   = first_chunk_q ? rbw_q : acc_q;
        res_n.chunk_length = clen;
        res_n.buf_offset   = done_q;
        res_n.is_last      = (left_n == '0);
      end
      S_ERR: begin
        res_n.kind    = srs_pkg::KIND_ERR;
        res_n.is_last = 1'b1;
      end
      default: res_n = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_DIV;
      S_DIV:   if (step_q == STW'(DW - 1)) state_d = S_FVOL;
      S_FVOL:  if (!ge) state_d = S_MUL;
      S_MUL:   if (step_q == STW'(BW - 1)) state_d = S_RBW;
      S_RBW:   state_d = S_RBB;
      S_RBB:   state_d = S_NXT;
      S_NXT:   state_d = S_CNT;
      S_CNT: begin
        if (r_q != '0) begin
          if (cnt_inc > CW'(MAX_CHUNKS)) state_d = S_ERR;
        end else if (seek_need) begin
          state_d = S_SEEK;
        end else if (len_q != '0) begin
          state_d = S_CHUNK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SEEK: begin
        if (load_en && last_seek) state_d = (len_q != '0) ? S_CHUNK : S_IDLE;
      end
      S_CHUNK: if (load_en && (left_n == '0)) state_d = S_IDLE;
      S_ERR:   if (load_en) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_v_q   <= 1'b0;
      expn_q    <= '0;
      last_op_q <= srs_pkg::OP_NONE;
    end else begin
      state_q <= state_d;
      if (load_en) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
      if ((state_q == S_CNT) && (r_q == '0)) begin
        expn_q <= nexp_q;
        if (seek_need && (len_q != '0)) last_op_q <= {1'b0, op_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) res_q <= res_n;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          first_q <= req_i.data.start_byte & AMASK;
          quo_q   <= req_i.data.start_byte & AMASK;
          len_q   <= req_i.data.req_length;
          op_q    <= req_i.data.opcode;
          n_q     <= n_i;
          bs_q    <= bs_i;
          span_q  <= SW'(n_i * bs_i);
          rem_q   <= '0;
          fvol_q  <= '0;
          step_q  <= '0;
        end
      end
      S_DIV: begin
        rem_q  <= ge ? alu_res.sum[SW-1:0] : div_t[SW-1:0];
        quo_q  <= {quo_q[DW-2:0], ge};
        if (step_q == STW'(DW - 1)) begin
          step_q <= '0;
          acc_q  <= '0;
          mplr_q <= bs_q;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
      S_FVOL: begin
        if (ge) begin
          rem_q  <= alu_res.sum[SW-1:0];
          fvol_q <= fvol_q + 1'b1;
        end
      end
      S_MUL: begin
        if (mplr_q[0]) acc_q <= alu_res.sum;
        quo_q  <= {quo_q[DW-2:0], 1'b0};
        mplr_q <= mplr_q >> 1;
        step_q <= step_q + 1'b1;
      end
      S_RBW: rbw_q <= alu_res.sum;
      S_RBB: rnext_q <= alu_res.sum;
      S_NXT: begin
        nexp_q <= alu_res.sum[AW-1:0];
        if (len_q == '0) begin
          cnt_q <= '0;
          r_q   <= '0;
        end else if (len_q <= {{(LW-BW){1'b0}}, firstlen}) begin
          cnt_q <= CW'(1);
          r_q   <= '0;
        end else begin
          cnt_q <= CW'(1);
          r_q   <= len_q - {{(LW-BW){1'b0}}, firstlen};
        end
      end
      S_CNT: begin
        if (r_q != '0) begin
          cnt_q <= cnt_inc;
          r_q   <= (ge && (alu_res.sum != '0)) ? alu_res.sum[LW-1:0] : '0;
        end else begin
          sidx_q        <= '0;
          vol_q         <= fvol_q;
          left_q        <= len_q;
          done_q        <= '0;
          first_chunk_q <= 1'b1;
        end
      end
      S_SEEK: if (load_en) sidx_q <= sidx_q + 1'b1;
      S_CHUNK: begin
        if (load_en) begin
          left_q        <= left_n;
          done_q        <= done_q + {{(LW-BW){1'b0}}, clen};
          first_chunk_q <= 1'b0;
          if (vol_wrap) begin
            vol_q   <= '0;
            acc_q   <= rnext_q;
            rnext_q <= alu_res.sum;
          end else begin
            vol_q <= vol_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (res_q.kind == srs_pkg::KIND_ERR)) |-> res_q.is_last)
    else $error("error result without last mark");

  a_chunk_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (res_q.kind == srs_pkg::KIND_CHUNK)) |-> (res_q.chunk_length != '0))
    else $error("empty chunk emitted");

  a_seek_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEEK) |-> (sidx_q < n_q))
    else $error("seek index beyond volume count");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DIV))
    else $error("accepted request did not start division");
endmodule

// File: rtl/core/stripe_request_splitter_top.sv
// ----------------------------------------------------------------------------
// stripe_request_splitter_top
// Splits striped-file requests into per-volume seeks and transfer chunks.
//
//  port     dir  payload
//  req_i    in   opcode, start_byte, req_length
//  res_o    out  kind, volume, vol_offset, chunk_length, buf_offset,
//                op_echo, is_last
//  cfg_*    in   write enable, register index, data
//
// One request runs a restoring division, a volume search, a shift-add
// multiply, 3 adds and a chunk count, all on the one shared adder; then
// one result per cycle while the output register is free.
// Reset: one volume, 8 KiB block, no previous operation.
// A stalled result holds in the output register; the next request is
// taken meanwhile and waits for that register before emitting.
// ----------------------------------------------------------------------------
module stripe_request_splitter_top #(
  parameter int MAX_VOLUMES = 8,
  parameter int MAX_CHUNKS  = 56,
  parameter int ADDR_BITS   = 48
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [srs_pkg::BS_W-1:0] cfg_data_i,
  srs_stream_if.sink               req_i,
  srs_stream_if.source             res_o
);
  localparam int NVW = $clog2(MAX_VOLUMES + 1);

  logic [srs_pkg::NV_W-1:0] nv_q;
  logic [srs_pkg::BS_W-1:0] bs_q, bs_eff;
  logic [NVW-1:0]           n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 4'd1;
      bs_q <= srs_pkg::DEF_BLOCK;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srs_pkg::CFG_NUM_VOLUMES: nv_q <= cfg_data_i[srs_pkg::NV_W-1:0];
        srs_pkg::CFG_BLOCK_SIZE:  bs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (nv_q == '0) begin
      n_eff = NVW'(1);
    end else if (32'(nv_q) > MAX_VOLUMES) begin
      n_eff = NVW'(MAX_VOLUMES);
    end else begin
      n_eff = NVW'(nv_q);
    end
    if (bs_q == '0) begin
      bs_eff = srs_pkg::DEF_BLOCK;
    end else if (bs_q > srs_pkg::MAX_BLOCK) begin
      bs_eff = srs_pkg::MAX_BLOCK;
    end else begin
      bs_eff = bs_q;
    end
  end

  srs_core #(
    .MAX_VOLUMES(MAX_VOLUMES),
    .MAX_CHUNKS (MAX_CHUNKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .n_i   (n_eff),
    .bs_i  (bs_eff),
    .req_i (req_i),
    .res_o (res_o)
  );
endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for stripe_request_splitter_top. Requests are driven through the
// request channel and checked result by result against an in-bench stripe
// address map, under random stalls on both sides and several register sets.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned TOP_NV    = 8;
  localparam longint unsigned TOP_CHUNK = 56;
  localparam longint unsigned ADDR_MSK  = 64'hFFFF_FFFF_FFFF;
  localparam int              DRAIN_CYC = 300;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic                     cfg_idx_i = srs_pkg::CFG_NUM_VOLUMES;
  logic [srs_pkg::BS_W-1:0] cfg_data_i = '0;
  logic                     req_fire = 1'b0;
  bit                       no_gaps = 1'b0;

  srs_stream_if #(.T(srs_pkg::req_t)) req_if ();
  srs_stream_if #(.T(srs_pkg::res_t)) res_if ();

  stripe_request_splitter_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  always #2 clk_i = ~clk_i;

  // Stripe map state kept by the bench
  logic [srs_pkg::NV_W-1:0]   vol_reg = 4'd1;
  logic [srs_pkg::BS_W-1:0]   blk_reg = srs_pkg::DEF_BLOCK;
  logic [srs_pkg::ADDR_W-1:0] next_byte = '0;
  logic [1:0]                 prev_op = srs_pkg::OP_NONE;

  srs_pkg::res_t expected_chunks[$];
  int            mismatches = 0;

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    res_if.ready = 1'b0;
  end

  always @(posedge clk_i) req_fire <= req_if.valid && req_if.ready;

  always @(negedge clk_i) res_if.ready = no_gaps || ($urandom_range(99) >= 30);

  function automatic longint unsigned eff_vols();
    longint unsigned n;
    n = vol_reg;
    if (n == 0) n = 1;
    if (n > TOP_NV) n = TOP_NV;
    return n;
  endfunction

  function automatic longint unsigned eff_block();
    longint unsigned b;
    b = blk_reg;
    if (b == 0) b = srs_pkg::DEF_BLOCK;
    if (b > srs_pkg::MAX_BLOCK) b = srs_pkg::MAX_BLOCK;
    return b;
  endfunction

  function automatic srs_pkg::res_t mk(logic [1:0] k, longint unsigned v,
                                       longint unsigned off, longint unsigned ln,
                                       longint unsigned bo, logic op);
    srs_pkg::res_t r;
    r.kind         = k;
    r.volume       = v[2:0];
    r.vol_offset   = off[srs_pkg::ADDR_W-1:0];
    r.chunk_length = ln[srs_pkg::BS_W-1:0];
    r.buf_offset   = bo[srs_pkg::LEN_W-1:0];
    r.op_echo      = op;
    r.is_last      = 1'b0;
    return r;
  endfunction

  // Split one request into seeks and chunks, or one error result, and update the map state unless it is an error
  task automatic split_request(input srs_pkg::req_t rq);
    longint unsigned n, bs, span, cyc, rem, fv, blk_off, firstlen, nch;
    longint unsigned first, length, done, vol, b, ln, off;
    srs_pkg::res_t   batch[$];
    n = eff_vols();
    bs = eff_block();
    first = rq.start_byte;
    length = rq.req_length;
    span = n * bs;
    cyc = first / span;
    rem = first - cyc * span;
    fv = rem / bs;
    blk_off = rem % bs;
    firstlen = bs - blk_off;
    if (length == 0) nch = 0;
    else if (length <= firstlen) nch = 1;
    else nch = 1 + (length - firstlen + bs - 1) / bs;
    if (nch > TOP_CHUNK) begin
      batch.push_back(mk(srs_pkg::KIND_ERR, 0, 0, 0, 0, rq.opcode));
    end else begin
      if (next_byte != rq.start_byte || prev_op != {1'b0, rq.opcode}) begin
        for (longint unsigned i = 0; i < n; i++) begin
          if (i < fv) off = (cyc + 1) * bs;
          else if (i == fv) off = cyc * bs + blk_off;
          else off = cyc * bs;
          batch.push_back(mk(srs_pkg::KIND_SEEK, i, off & ADDR_MSK, 0, 0, rq.opcode));
        end
        if (length > 0) prev_op = {1'b0, rq.opcode};
      end
      next_byte = (first + length) & ADDR_MSK;
      done = 0;
      vol = fv;
      while (done < length) begin
        b = first + done;
        ln = (done == 0) ? firstlen : bs;
        off = (b / span) * bs + b % bs;
        if (ln > length - done) ln = length - done;
        batch.push_back(mk(srs_pkg::KIND_CHUNK, vol, off & ADDR_MSK, ln, done, rq.opcode));
        done += ln;
        vol++;
        if (vol == n) vol = 0;
      end
    end
    if (batch.size() > 0) batch[batch.size()-1].is_last = 1'b1;
    foreach (batch[i]) expected_chunks.push_back(batch[i]);
  endtask

  always @(posedge clk_i) begin
    srs_pkg::res_t e;
    srs_pkg::res_t a;
    if (rst_ni && res_if.valid && res_if.ready) begin
      a = res_if.data;
      if (expected_chunks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", a);
      end else begin
        e = expected_chunks.pop_front();
        if (a.kind !== e.kind || a.volume !== e.volume || a.vol_offset !== e.vol_offset ||
            a.chunk_length !== e.chunk_length || a.buf_offset !== e.buf_offset ||
            a.op_echo !== e.op_echo || a.is_last !== e.is_last) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, a);
        end
      end
    end
  end

  task automatic send_request(input logic op, input longint unsigned start,
                              input longint unsigned len);
    srs_pkg::req_t rq;
    rq.opcode = op;
    rq.start_byte = start[srs_pkg::ADDR_W-1:0];
    rq.req_length = len[srs_pkg::LEN_W-1:0];
    while (!no_gaps && $urandom_range(99) < 30) @(negedge clk_i);
    split_request(rq);
    req_if.valid = 1'b1;
    req_if.data  = rq;
    do @(negedge clk_i); while (!req_fire);
    req_if.valid = 1'b0;
  endtask

  task automatic drain();
    wait (expected_chunks.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [srs_pkg::BS_W-1:0] val);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == srs_pkg::CFG_NUM_VOLUMES) vol_reg = val[srs_pkg::NV_W-1:0];
    else blk_reg = val;
  endtask

  function automatic longint unsigned pick_length(longint unsigned bs);
    int              t;
    longint unsigned ln;
    t = $urandom_range(99);
    if (t < 5) return 0;
    if (t < 10) return $urandom_range(25'h1FF_FFFF) % ((64'd1 << 24) + 1);
    ln = longint'($urandom_range(1, 40)) * bs;
    ln = ln - (longint'($urandom()) % bs);
    if (ln > (64'd1 << 24)) ln = 64'd1 << 24;
    if (ln == 0) ln = 1;
    return ln;
  endfunction

  function automatic longint unsigned rand_addr();
    return {$urandom(), $urandom()} & ADDR_MSK;
  endfunction

  task automatic test_reset_map();
    send_request(1'b0, 0, 0);
    send_request(1'b0, 0, 8192);
    send_request(1'b0, 8192, 1);
    send_request(1'b1, 8193, 100);
    send_request(1'b1, 0, 0);
    send_request(1'b0, ADDR_MSK, 16);
    send_request(1'b1, 0, 64'd1 << 24);
    send_request(1'b0, 0, 56 * 8192);
    send_request(1'b0, 0, 56 * 8192 + 1);
    send_request(1'b1, ADDR_MSK - 100, 25'h0AAAAAA & 25'h3FFFF);
  endtask

  task automatic test_reg_extremes();
    write_reg(srs_pkg::CFG_NUM_VOLUMES, 0);
    write_reg(srs_pkg::CFG_BLOCK_SIZE, 0);
    send_request(1'b0, 12345, 20000);
    write_reg(srs_pkg::CFG_NUM_VOLUMES, 15);
    write_reg(srs_pkg::CFG_BLOCK_SIZE, 21'h1F_FFFF);
    send_request(1'b1, ADDR_MSK - 3000000, 64'd1 << 24);
    write_reg(srs_pkg::CFG_NUM_VOLUMES, 8);
    write_reg(srs_pkg::CFG_BLOCK_SIZE, srs_pkg::MAX_BLOCK);
    send_request(1'b0, 48'h5555_5555_5555, 64'd1 << 24);
    write_reg(srs_pkg::CFG_NUM_VOLUMES, 1);
    write_reg(srs_pkg::CFG_BLOCK_SIZE, 1);
    send_request(1'b0, 48'hAAAA_AAAA_AAAA, 56);
    send_request(1'b0, 48'hAAAA_AAAA_AAAA + 56, 57);
    send_request(1'b1, 0, 0);
  endtask

  task automatic test_random_map(input int nv, input int bs, input int count);
    longint unsigned blk, start;
    logic            op;
    write_reg(srs_pkg::CFG_NUM_VOLUMES, nv[srs_pkg::BS_W-1:0]);
    write_reg(srs_pkg::CFG_BLOCK_SIZE, bs[srs_pkg::BS_W-1:0]);
    blk = eff_block();
    for (int i = 0; i < count; i++) begin
      no_gaps = (i >= count / 2 && i < count / 2 + 15);
      op = prev_op[0];
      if (prev_op == srs_pkg::OP_NONE || $urandom_range(99) < 15) op = $urandom_range(1);
      if ($urandom_range(99) < 70) start = next_byte;
      else if ($urandom_range(99) < 20) start = ADDR_MSK - $urandom_range(2 * blk);
      else start = rand_addr();
      send_request(op, start, pick_length(blk));
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_pause_until_empty();
    send_request(1'b0, next_byte, 3 * eff_block());
    drain();
    send_request(1'b0, next_byte, eff_block() + 7);
    send_request(1'b1, next_byte, 1);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_map();
    test_reg_extremes();
    test_random_map(1, 8192, 58);
    test_random_map(8, 1, 58);
    test_random_map(3, 7, 58);
    test_random_map(5, 1048576, 58);
    test_random_map(0, 0, 58);
    test_random_map(15, 2097151, 58);
    test_random_map(4, 4096, 58);
    test_random_map(2, 1000, 58);
    test_pause_until_empty();
    drain();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/srs_pkg.sv
rtl/core/srs_stream_if.sv
rtl/core/srs_alu.sv
rtl/core/srs_core.sv
rtl/core/stripe_request_splitter_top.sv
test/tb.sv
